// ===== src/xsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// X25519 scalar multiply package
// Shared widths, register map, microcode and payload types for the
// Montgomery ladder engine.
// ----------------------------------------------------------------------------
package xsm_pkg;

  localparam int unsigned WORD_W          = 64;
  localparam int unsigned NWORDS          = 4;
  localparam int unsigned FE_W            = 256;
  localparam int unsigned LIMB_W          = 32;
  localparam int unsigned NLIMBS          = 8;
  localparam int unsigned NREGS           = 16;
  localparam int unsigned PC_W            = 5;
  localparam int unsigned INV_W           = 8;
  localparam int unsigned SCALAR_BITS_DEF = 256;

  localparam logic [INV_W-1:0] INV_TOP = 8'd254;
  localparam logic [FE_W-1:0]  A24_VALUE = 256'd121665;

  typedef logic [3:0] addr_t;

  // Field element register map.
  localparam addr_t R_X2  = 4'd0;
  localparam addr_t R_Z2  = 4'd1;
  localparam addr_t R_X3  = 4'd2;
  localparam addr_t R_Z3  = 4'd3;
  localparam addr_t R_X1  = 4'd4;
  localparam addr_t R_A24 = 4'd5;
  localparam addr_t R_A   = 4'd6;
  localparam addr_t R_B   = 4'd7;
  localparam addr_t R_AA  = 4'd8;
  localparam addr_t R_BB  = 4'd9;
  localparam addr_t R_E   = 4'd10;
  localparam addr_t R_C   = 4'd11;
  localparam addr_t R_D   = 4'd12;
  localparam addr_t R_DA  = 4'd13;
  localparam addr_t R_CB  = 4'd14;
  localparam addr_t R_T   = 4'd15;

  // Constant selectors for the set operation.
  localparam addr_t K_ZERO = 4'd0;
  localparam addr_t K_ONE  = 4'd1;
  localparam addr_t K_A24  = 4'd2;

  // Input actions.
  localparam logic [1:0] ACT_LOAD_SCALAR = 2'd0;
  localparam logic [1:0] ACT_LOAD_POINT  = 2'd1;
  localparam logic [1:0] ACT_START       = 2'd2;

  // Microcode addresses with special sequencing.
  localparam logic [PC_W-1:0] PC_LADDER     = 5'd5;
  localparam logic [PC_W-1:0] PC_LADDER_END = 5'd22;
  localparam logic [PC_W-1:0] PC_INV_INIT   = 5'd23;
  localparam logic [PC_W-1:0] PC_SQR        = 5'd24;
  localparam logic [PC_W-1:0] PC_MULZ       = 5'd25;
  localparam logic [PC_W-1:0] PC_FINAL      = 5'd26;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_MOV = 3'd3,
    OP_SET = 3'd4
  } op_e;

  typedef struct packed {
    op_e   op;
    addr_t dst;
    addr_t sa;
    addr_t sb;
  } uop_t;

  typedef struct packed {
    logic issue;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [1:0]        word;
    logic [WORD_W-1:0] data;
  } load_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  word_index;
    logic [63:0] word_data;
  } in_t;

  typedef struct packed {
    logic [63:0] result_word;
    logic [1:0]  result_index;
    logic        last_word;
  } out_t;

  function automatic uop_t mk(input op_e op, input addr_t d, input addr_t a, input addr_t b);
    uop_t u;
    u.op  = op;
    u.dst = d;
    u.sa  = a;
    u.sb  = b;
    return u;
  endfunction

  // Set-up, one ladder step, inversion by square and multiply, final product.
  function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      5'd0:    u = mk(OP_SET, R_X2,  R_X2,  K_ONE);
      5'd1:    u = mk(OP_SET, R_Z2,  R_Z2,  K_ZERO);
      5'd2:    u = mk(OP_SET, R_Z3,  R_Z3,  K_ONE);
      5'd3:    u = mk(OP_SET, R_A24, R_A24, K_A24);
      5'd4:    u = mk(OP_MOV, R_X3,  R_X1,  R_X1);
      5'd5:    u = mk(OP_ADD, R_A,   R_X2,  R_Z2);
      5'd6:    u = mk(OP_SUB, R_B,   R_X2,  R_Z2);
      5'd7:    u = mk(OP_MUL, R_AA,  R_A,   R_A);
      5'd8:    u = mk(OP_MUL, R_BB,  R_B,   R_B);
      5'd9:    u = mk(OP_SUB, R_E,   R_AA,  R_BB);
      5'd10:   u = mk(OP_ADD, R_C,   R_X3,  R_Z3);
      5'd11:   u = mk(OP_SUB, R_D,   R_X3,  R_Z3);
      5'd12:   u = mk(OP_MUL, R_DA,  R_D,   R_A);
      5'd13:   u = mk(OP_MUL, R_CB,  R_C,   R_B);
      5'd14:   u = mk(OP_ADD, R_T,   R_DA,  R_CB);
      5'd15:   u = mk(OP_MUL, R_X3,  R_T,   R_T);
      5'd16:   u = mk(OP_SUB, R_T,   R_DA,  R_CB);
      5'd17:   u = mk(OP_MUL, R_T,   R_T,   R_T);
      5'd18:   u = mk(OP_MUL, R_Z3,  R_T,   R_X1);
      5'd19:   u = mk(OP_MUL, R_X2,  R_AA,  R_BB);
      5'd20:   u = mk(OP_MUL, R_T,   R_A24, R_E);
      5'd21:   u = mk(OP_ADD, R_T,   R_T,   R_AA);
      5'd22:   u = mk(OP_MUL, R_Z2,  R_E,   R_T);
      5'd23:   u = mk(OP_SET, R_A,   R_A,   K_ONE);
      5'd24:   u = mk(OP_MUL, R_A,   R_A,   R_A);
      5'd25:   u = mk(OP_MUL, R_A,   R_A,   R_Z2);
      5'd26:   u = mk(OP_MUL, R_T,   R_X2,  R_A);
      default: u = mk(OP_MOV, R_T,   R_T,   R_T);
    endcase
    return u;
  endfunction

endpackage

// ===== src/xsm_modmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular multiplier
// Computes a*b modulo 2^255-19 as a value below 2^256, one 32-bit limb of a
// per cycle, most significant first, through a three-stage pipeline.
// ----------------------------------------------------------------------------
module xsm_modmul (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [xsm_pkg::FE_W-1:0] a_i,
  input  logic [xsm_pkg::FE_W-1:0] b_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic [xsm_pkg::FE_W-1:0] res_o
);
  import xsm_pkg::*;

  localparam int unsigned IDX_W = $clog2(NLIMBS);
  localparam int unsigned PROD_W = FE_W + LIMB_W;

  logic [FE_W-1:0]   a_q, b_q, acc_q, acc_d;
  logic [FE_W-1:0]   e_q, o_q, e_d, o_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [IDX_W-1:0]  idx_q;
  logic              run_q, v1_q, l1_q, v2_q, l2_q, done_q;
  logic [PROD_W:0]   t_sum;
  logic [FE_W:0]     u_sum;

  // Even and odd limb products do not overlap, so each packs into one word.
  always_comb begin
    for (int j = 0; j < NLIMBS / 2; j++) begin
      e_d[2*LIMB_W*j +: 2*LIMB_W] = (2*LIMB_W)'(a_q[FE_W-1 -: LIMB_W])
                                  * (2*LIMB_W)'(b_q[2*LIMB_W*j +: LIMB_W]);
      o_d[2*LIMB_W*j +: 2*LIMB_W] = (2*LIMB_W)'(a_q[FE_W-1 -: LIMB_W])
                                  * (2*LIMB_W)'(b_q[2*LIMB_W*j + LIMB_W +: LIMB_W]);
    end
    prod_d = {{LIMB_W{1'b0}}, e_q} + {o_q, {LIMB_W{1'b0}}};
  end

  // Shift the accumulator by one limb, add the product and fold the bits
  // above 2^256 back in using 2^256 = 38 modulo p.
  always_comb begin
    t_sum = {1'b0, acc_q, {LIMB_W{1'b0}}} + {1'b0, prod_q};
    u_sum = {1'b0, t_sum[FE_W-1:0]} + (FE_W+1)'(t_sum[PROD_W:FE_W]) * (FE_W+1)'(38);
    acc_d = u_sum[FE_W-1:0] + (u_sum[FE_W] ? FE_W'(38) : '0);
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (run_q) begin
      a_q <= a_q << LIMB_W;
    end
    e_q    <= e_d;
    o_q    <= o_d;
    prod_q <= prod_d;
    if (start_i) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      idx_q  <= '0;
      v1_q   <= 1'b0;
      l1_q   <= 1'b0;
      v2_q   <= 1'b0;
      l2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (start_i) begin
        run_q <= 1'b1;
        idx_q <= IDX_W'(NLIMBS - 1);
      end else if (run_q) begin
        run_q <= (idx_q != '0);
        idx_q <= idx_q - 1'b1;
      end
      v1_q   <= run_q;
      l1_q   <= run_q && (idx_q == '0);
      v2_q   <= v1_q;
      l2_q   <= l1_q;
      done_q <= v2_q && l2_q;
    end
  end

  assign busy_o = run_q | v1_q | v2_q;
  assign done_o = done_q;
  assign res_o  = acc_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o)
    else $error("multiplier started while busy");

endmodule

// ===== src/xsm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Field element datapath
// Register memory of sixteen field elements, with add, subtract, move and set
// done in the cycle after the read, and products from the multiplier.
// ----------------------------------------------------------------------------
module xsm_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  xsm_pkg::cmd_t            cmd_i,
  input  xsm_pkg::load_t           load_i,
  output logic                     done_o,
  output logic [xsm_pkg::FE_W-1:0] wb_o
);
  import xsm_pkg::*;

  logic [WORD_W-1:0] mem_q [NREGS][NWORDS];
  logic [FE_W-1:0]   rd_a_q, rd_b_q;
  logic              ph1_q;
  op_e               op_q;
  addr_t             dst_q, sb_q;
  logic [FE_W-1:0]   alu_res, wdata, mul_res;
  logic [FE_W:0]     sum, diff, sum_f, diff_1;
  logic              mul_start, mul_done, mul_busy;
  logic [WORD_W-1:0] ld_data;

  assign mul_start = ph1_q && (op_q == OP_MUL);

  xsm_modmul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (rd_a_q),
    .b_i    (rd_b_q),
    .busy_o (mul_busy),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  always_comb begin
    sum    = {1'b0, rd_a_q} + {1'b0, rd_b_q};
    sum_f  = {1'b0, sum[FE_W-1:0]} + (sum[FE_W] ? (FE_W+1)'(38) : '0);
    diff   = {1'b0, rd_a_q} - {1'b0, rd_b_q};
    // A borrow means 2^256 was added, which is 38 too much modulo p.
    diff_1 = {1'b0, diff[FE_W-1:0]} - (diff[FE_W] ? (FE_W+1)'(38) : '0);
    case (op_q)
      OP_ADD: alu_res = sum_f[FE_W] ? sum_f[FE_W-1:0] + FE_W'(38) : sum_f[FE_W-1:0];
      OP_SUB: alu_res = diff_1[FE_W] ? diff_1[FE_W-1:0] - FE_W'(38) : diff_1[FE_W-1:0];
      OP_MOV: alu_res = rd_a_q;
      OP_SET: begin
        case (sb_q)
          K_ONE:   alu_res = FE_W'(1);
          K_A24:   alu_res = A24_VALUE;
          default: alu_res = '0;
        endcase
      end
      default: alu_res = '0;
    endcase
  end

  assign done_o  = (ph1_q && (op_q != OP_MUL)) || mul_done;
  assign wdata   = mul_done ? mul_res : alu_res;
  assign wb_o    = wdata;
  // Bit 255 of the loaded coordinate is dropped.
  assign ld_data = (load_i.word == 2'(NWORDS - 1)) ? {1'b0, load_i.data[WORD_W-2:0]}
                                                   : load_i.data;

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      for (int w = 0; w < NWORDS; w++) begin
        rd_a_q[w*WORD_W +: WORD_W] <= mem_q[cmd_i.uop.sa][w];
        rd_b_q[w*WORD_W +: WORD_W] <= mem_q[cmd_i.uop.sb][w];
      end
      op_q  <= cmd_i.uop.op;
      dst_q <= cmd_i.uop.dst;
      sb_q  <= cmd_i.uop.sb;
    end
    if (load_i.en) begin
      mem_q[R_X1][load_i.word] <= ld_data;
    end else if (done_o) begin
      for (int w = 0; w < NWORDS; w++) begin
        mem_q[dst_q][w] <= wdata[w*WORD_W +: WORD_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph1_q <= 1'b0;
    end else begin
      ph1_q <= cmd_i.issue;
    end
  end

  a_issue_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> !mul_busy && !ph1_q)
    else $error("operation issued while another is in flight");

endmodule

// ===== src/xsm_final.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Final reduction and output
// Brings the affine result to its canonical residue below p and sends it
// out as four 64-bit items, least significant first.
// ----------------------------------------------------------------------------
module xsm_final (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  logic [xsm_pkg::FE_W-1:0] value_i,
  output logic                     busy_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output xsm_pkg::out_t            out_o
);
  import xsm_pkg::*;

  logic [FE_W-1:0] r1;
  logic [FE_W-2:0] r2, c_q, res_d;
  logic [FE_W-1:0] res_q, t_sum;
  logic            s1_q, oval_q;
  logic [1:0]      idx_q;

  always_comb begin
    r1    = {1'b0, value_i[FE_W-2:0]} + (value_i[FE_W-1] ? FE_W'(19) : '0);
    r2    = r1[FE_W-2:0] + (r1[FE_W-1] ? (FE_W-1)'(19) : '0);
    // The value is now below 2^255; it is at least p when adding 19 reaches bit 255.
    t_sum = {1'b0, c_q} + FE_W'(19);
    res_d = t_sum[FE_W-1] ? t_sum[FE_W-2:0] : c_q;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      c_q <= r2;
    end
    if (s1_q) begin
      res_q <= {1'b0, res_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      oval_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      s1_q <= load_i;
      if (s1_q) begin
        oval_q <= 1'b1;
        idx_q  <= '0;
      end else if (oval_q && out_ready_i) begin
        oval_q <= (idx_q != 2'(NWORDS - 1));
        idx_q  <= idx_q + 1'b1;
      end
    end
  end

  assign busy_o             = s1_q | oval_q;
  assign out_valid_o        = oval_q;
  assign out_o.result_word  = res_q[{idx_q, 6'b0} +: WORD_W];
  assign out_o.result_index = idx_q;
  assign out_o.last_word    = (idx_q == 2'(NWORDS - 1));

endmodule

// ===== src/x25519_scalar_multiply.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// X25519 scalar multiply
// Montgomery ladder on Curve25519 with inversion and canonical output.
// ----------------------------------------------------------------------------
// Load the scalar and the u-coordinate as four 64-bit words each, one word per
// item, then send a start item. The block works on one item at a time: a start
// runs the whole scalar multiply before the next item is taken. Its run time is
// set by the single modular multiplier, which computes the ten products of a
// ladder step, the 508 products of the inversion and the final product, with
// the field elements held in a sixteen-entry memory.
// Four result items follow, least significant word first. The scalar is used
// as loaded, without clamping; bit 255 of the coordinate is ignored and a zero
// Z coordinate gives a zero result. Loads and starts are not taken while a
// multiplication runs.
module x25519_scalar_multiply #(
  parameter int unsigned SCALAR_BITS = xsm_pkg::SCALAR_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  xsm_pkg::in_t   in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output xsm_pkg::out_t  out_o
);
  import xsm_pkg::*;

  localparam int unsigned BIT_W = (SCALAR_BITS > 1) ? $clog2(SCALAR_BITS) : 1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ISSUE = 3'b010,
    S_WAIT  = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic [PC_W-1:0]       pc_q, pc_d;
  logic [BIT_W-1:0]      bit_q, bit_d;
  logic [INV_W-1:0]      inv_q, inv_d;
  logic [WORD_W-1:0]     scalar_q [NWORDS];
  logic [FE_W-1:0]       scalar_flat, wb;
  logic                  accept, in_ladder, swap, dp_done, fin_busy, fin_load;
  uop_t                  uop;
  cmd_t                  cmd;
  load_t                 load;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    for (int w = 0; w < NWORDS; w++) begin
      scalar_flat[w*WORD_W +: WORD_W] = scalar_q[w];
    end
  end

  // The ladder swap is done by renaming: while the current scalar bit is set,
  // X2/Z2 and X3/Z3 trade places in the memory.
  assign in_ladder = (pc_q >= PC_LADDER) && (pc_q <= PC_LADDER_END);
  assign swap      = in_ladder && scalar_flat[8'(bit_q)];

  function automatic addr_t map_addr(input addr_t a, input logic sw);
    return (sw && (a <= R_Z3)) ? (a ^ 4'd2) : a;
  endfunction

  always_comb begin
    uop       = uop_rom(pc_q);
    cmd.uop   = uop;
    cmd.uop.dst = map_addr(uop.dst, swap);
    cmd.uop.sa  = map_addr(uop.sa, swap);
    cmd.uop.sb  = (uop.op == OP_SET) ? uop.sb : map_addr(uop.sb, swap);
    cmd.issue = (state_q == S_ISSUE) && !((pc_q == PC_FINAL) && fin_busy);
  end

  assign load.en   = accept && (in_i.action == ACT_LOAD_POINT);
  assign load.word = in_i.word_index;
  assign load.data = in_i.word_data;

  assign fin_load = (state_q == S_WAIT) && dp_done && (pc_q == PC_FINAL);

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    bit_d   = bit_q;
    inv_d   = inv_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (in_i.action == ACT_START)) begin
          state_d = S_ISSUE;
          pc_d    = '0;
          bit_d   = BIT_W'(SCALAR_BITS - 1);
        end
      end
      S_ISSUE: begin
        if (cmd.issue) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (dp_done) begin
          state_d = S_ISSUE;
          pc_d    = pc_q + 1'b1;
          if (pc_q == PC_LADDER_END) begin
            if (bit_q != '0) begin
              pc_d  = PC_LADDER;
              bit_d = bit_q - 1'b1;
            end
          end else if (pc_q == PC_INV_INIT) begin
            inv_d = INV_TOP;
          end else if (pc_q == PC_SQR || pc_q == PC_MULZ) begin
            // Exponent p-2 has zero bits at positions two and four.
            if (pc_q == PC_SQR && inv_q != 8'd2 && inv_q != 8'd4) begin
              pc_d = PC_MULZ;
            end else if (inv_q == '0) begin
              pc_d = PC_FINAL;
            end else begin
              pc_d  = PC_SQR;
              inv_d = inv_q - 1'b1;
            end
          end else if (pc_q == PC_FINAL) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept && (in_i.action == ACT_LOAD_SCALAR)) begin
      scalar_q[in_i.word_index] <= in_i.word_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      bit_q   <= '0;
      inv_q   <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      bit_q   <= bit_d;
      inv_q   <= inv_d;
    end
  end

  xsm_datapath u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .load_i(load),
    .done_o(dp_done),
    .wb_o  (wb)
  );

  xsm_final u_fin (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fin_load),
    .value_i    (wb),
    .busy_o     (fin_busy),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_done |-> state_q == S_WAIT)
    else $error("operation completed with none outstanding");

  a_final_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_load |-> !fin_busy)
    else $error("result overwrote an undelivered result");

endmodule

// ===== tb/tb_x25519_scalar_multiply.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// X25519 scalar multiply testbench
// Drives scalar and point loads and start items through the valid/ready
// input, predicts each affine u-coordinate with plain arithmetic modulo
// 2^255-19, and checks every result item against the predicted words.
// ----------------------------------------------------------------------------
module tb_x25519_scalar_multiply;

  import xsm_pkg::*;

  typedef logic [255:0] fe_t;

  localparam fe_t        PRIME      = (256'd1 << 255) - 256'd19;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // Long enough to outlast a whole multiplication, so the block fills up.
  localparam int         HOLD_LEN   = 60_000;
  localparam int         TAIL_LEN   = 200;
  localparam longint     CYCLE_CAP  = 12_000_000;

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_ready_o;
  in_t   in_i;
  logic  out_valid_o;
  logic  out_ready_i;
  out_t  out_o;

  in_t    pending_items[$];
  out_t   expected_words[$];
  logic [63:0] scalar_words[4];
  logic [63:0] point_words[4];
  int     n_items;
  int     n_accepted;
  int     n_results;
  int     n_errors = 0;
  int     send_idle;
  int     recv_idle;
  int     hold_left;
  bit     hold_done;
  longint n_cycles = 0;

  x25519_scalar_multiply dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic fe_t f_add(input fe_t a, input fe_t b);
    logic [256:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PRIME}) s = s - {1'b0, PRIME};
    return s[255:0];
  endfunction

  function automatic fe_t f_sub(input fe_t a, input fe_t b);
    logic [256:0] s;
    s = {1'b0, a} + {1'b0, PRIME} - {1'b0, b};
    if (s >= {1'b0, PRIME}) s = s - {1'b0, PRIME};
    return s[255:0];
  endfunction

  function automatic fe_t f_mul(input fe_t a, input fe_t b);
    logic [511:0] t;
    t = {256'd0, a} * {256'd0, b};
    t = t % {256'd0, PRIME};
    return t[255:0];
  endfunction

  // Affine u-coordinate of scalar * point, taken from the current stores.
  function automatic fe_t ladder_result();
    fe_t x1, x2, z2, x3, z3, a, aa, b, bb, e, c, d, da, cb, t, inv;
    bit  prev, bt, sw;
    x1 = {point_words[3], point_words[2], point_words[1], point_words[0]};
    x1[255] = 1'b0;
    if (x1 >= PRIME) x1 = x1 - PRIME;
    x2 = 256'd1; z2 = 256'd0; x3 = x1; z3 = 256'd1; prev = 1'b0;
    for (int i = 255; i >= 0; i--) begin
      bt = scalar_words[i / 64][i % 64];
      sw = bt ^ prev;
      prev = bt;
      if (sw) begin
        t = x2; x2 = x3; x3 = t;
        t = z2; z2 = z3; z3 = t;
      end
      a  = f_add(x2, z2);
      aa = f_mul(a, a);
      b  = f_sub(x2, z2);
      bb = f_mul(b, b);
      e  = f_sub(aa, bb);
      c  = f_add(x3, z3);
      d  = f_sub(x3, z3);
      da = f_mul(d, a);
      cb = f_mul(c, b);
      t  = f_add(da, cb);
      x3 = f_mul(t, t);
      t  = f_sub(da, cb);
      z3 = f_mul(f_mul(t, t), x1);
      x2 = f_mul(aa, bb);
      z2 = f_mul(e, f_add(f_mul(256'd121665, e), aa));
    end
    if (prev) begin
      x2 = x3;
      z2 = z3;
    end
    // Fermat inversion; zero stays zero.
    inv = 256'd1;
    for (int i = 254; i >= 0; i--) begin
      inv = f_mul(inv, inv);
      if (i != 2 && i != 4) inv = f_mul(inv, z2);
    end
    return f_mul(x2, inv);
  endfunction

  task automatic predict_item(input in_t it);
    fe_t  r;
    out_t o;
    case (it.action)
      ACT_LOAD_SCALAR: scalar_words[it.word_index] = it.word_data;
      ACT_LOAD_POINT:  point_words[it.word_index]  = it.word_data;
      ACT_START: begin
        r = ladder_result();
        for (int k = 0; k < 4; k++) begin
          o.result_word  = r[64*k +: 64];
          o.result_index = k[1:0];
          o.last_word    = (k == 3);
          expected_words.push_back(o);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    n_errors++;
  endtask

  task automatic push_item(input logic [1:0] act, input logic [1:0] idx,
                           input logic [63:0] data);
    in_t it;
    it.action     = act;
    it.word_index = idx;
    it.word_data  = data;
    pending_items.push_back(it);
  endtask

  task automatic push_operands(input fe_t k, input fe_t u);
    for (int w = 0; w < 4; w++) push_item(ACT_LOAD_SCALAR, w[1:0], k[64*w +: 64]);
    for (int w = 0; w < 4; w++) push_item(ACT_LOAD_POINT, w[1:0], u[64*w +: 64]);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  always_comb begin
    if (n_accepted < n_items / 3) begin
      send_idle = 10;
      recv_idle = 71;
    end else if (n_accepted < (2 * n_items) / 3) begin
      send_idle = 71;
      recv_idle = 10;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
  end

  // Input driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_i       <= '0;
      n_accepted <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_item(in_i);
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_i       <= pending_items.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long back-pressure once, when the second set of results appears.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && out_valid_o && n_results >= 4) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  // Result monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      n_results   <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_results <= n_results + 1;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected item", out_o.result_word, '0);
        end else begin
          want = expected_words.pop_front();
          if (out_o.result_word !== want.result_word)
            report_mismatch("result_word", out_o.result_word, want.result_word);
          if (out_o.result_index !== want.result_index)
            report_mismatch("result_index", 64'(out_o.result_index),
                            64'(want.result_index));
          if (out_o.last_word !== want.last_word)
            report_mismatch("last_word", 64'(out_o.last_word), 64'(want.last_word));
        end
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    fe_t k, u;
    n_items  = 1;
    rst_ni   = 1'b0;

    // Directed: all-ones scalar with an all-ones point (top bit dropped, above p).
    push_operands({256{1'b1}}, {256{1'b1}});
    push_item(ACT_START, 2'd0, 64'd0);
    push_item(ACT_UNUSED, 2'd3, {64{1'b1}});
    // Zero scalar leaves Z2 at zero, so the result is zero.
    push_item(ACT_LOAD_POINT, 2'd0, 64'd9);
    for (int w = 1; w < 4; w++) push_item(ACT_LOAD_POINT, w[1:0], 64'd0);
    for (int w = 0; w < 4; w++) push_item(ACT_LOAD_SCALAR, w[1:0], 64'd0);
    push_item(ACT_START, 2'd3, {64{1'b1}});
    // Point equal to p, i.e. zero, with a scalar of one.
    push_operands(256'd1, PRIME);
    push_item(ACT_START, 2'd1, 64'd0);

    // Random: mostly complete operand sets followed by a start.
    for (int s = 0; s < 8; s++) begin
      k = {rand64(), rand64(), rand64(), rand64()};
      u = {rand64(), rand64(), rand64(), rand64()};
      if ($urandom_range(3) == 0) k = k >> $urandom_range(255);
      if ($urandom_range(3) == 0) u = u >> $urandom_range(255);
      push_operands(k, u);
      for (int n = $urandom_range(4); n > 0; n--)
        push_item(2'($urandom_range(3)), 2'($urandom_range(3)), rand64());
      push_item(ACT_START, 2'($urandom_range(3)), rand64());
    end
    n_items = pending_items.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_words.size() > 0) @(posedge clk_i);
    repeat (TAIL_LEN) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
